[sv/assert_macros.svh]
// assertion macros shared by the lock table modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ILTM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lock table assertion failed");

// antecedent implies consequent in the next cycle
`define ILTM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lock table assertion failed");

`endif

[sv/iltm_pkg.sv]
// types, constants and helper functions of the intent lock table
package iltm_pkg;

    localparam int MAX_REQ   = 32;
    localparam int NUM_RES   = 16;
    localparam int NUM_MODES = 5;
    localparam int ID_W      = 5;
    localparam int LINK_W    = 6;
    localparam int RES_W     = 4;
    localparam int MODE_W    = 3;
    localparam int CNT_W     = 6;
    localparam int OP_W      = 5;

    localparam logic [LINK_W-1:0] NULL_LINK = 6'd63;

    localparam logic [MODE_W-1:0] MODE_X = 3'd4;

    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_GRANTED = 2'd1;
    localparam logic [1:0] ST_WAITING = 2'd2;

    localparam logic [1:0] OUT_GRANTED  = 2'd0;
    localparam logic [1:0] OUT_WAITING  = 2'd1;
    localparam logic [1:0] OUT_RELEASED = 2'd2;
    localparam logic [1:0] OUT_ERROR    = 2'd3;

    // datapath commands
    localparam logic [OP_W-1:0] OP_NOP    = 5'd0;
    localparam logic [OP_W-1:0] OP_LATCH  = 5'd1;
    localparam logic [OP_W-1:0] OP_LOCK   = 5'd2;
    localparam logic [OP_W-1:0] OP_LINK   = 5'd3;
    localparam logic [OP_W-1:0] OP_UCHK   = 5'd4;
    localparam logic [OP_W-1:0] OP_ULOAD  = 5'd5;
    localparam logic [OP_W-1:0] OP_UREL   = 5'd6;
    localparam logic [OP_W-1:0] OP_UNLP   = 5'd7;
    localparam logic [OP_W-1:0] OP_UNLN   = 5'd8;
    localparam logic [OP_W-1:0] OP_UCLR   = 5'd9;
    localparam logic [OP_W-1:0] OP_SRD    = 5'd10;
    localparam logic [OP_W-1:0] OP_SCHK   = 5'd11;
    localparam logic [OP_W-1:0] OP_SGRANT = 5'd12;
    localparam logic [OP_W-1:0] OP_WB     = 5'd13;
    localparam logic [OP_W-1:0] OP_ERD    = 5'd14;
    localparam logic [OP_W-1:0] OP_EOUT   = 5'd15;

    localparam logic [NUM_MODES-1:0] CONFLICT [NUM_MODES] = '{
        5'b00000,
        5'b10000,
        5'b11000,
        5'b10100,
        5'b11110
    };

    typedef struct packed {
        logic              action;
        logic [ID_W-1:0]   request_id;
        logic [RES_W-1:0]  resource_slot;
        logic [MODE_W-1:0] lock_mode;
        logic              at_front;
        logic              compat_first;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0] out_request;
        logic [1:0]      outcome;
        logic            waiters_pending;
        logic            last;
    } t_out;

    typedef struct packed {
        logic [RES_W-1:0]  resource;
        logic [MODE_W-1:0] mode;
        logic [1:0]        status;
        logic              compat;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } t_req;

    typedef struct packed {
        logic [NUM_MODES-1:0][CNT_W-1:0] granted;
        logic [NUM_MODES-1:0][CNT_W-1:0] waiting;
        logic [CNT_W-1:0]                cf_count;
        logic [LINK_W-1:0]               head;
        logic [LINK_W-1:0]               tail;
    } t_row;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [1:0]      outcome;
    } t_bent;

    typedef struct packed {
        logic action;
        logic lk_wait;
        logic u_free;
        logic u_granted;
        logic check;
        logic it_null;
        logic s_clash;
        logic s_stop;
        logic s_x;
        logic last_out;
    } t_status;

    localparam t_req REQ_RESET = '{resource: '0, mode: '0, status: ST_FREE, compat: 1'b0,
                                   next: NULL_LINK, prev: NULL_LINK};

    localparam t_row ROW_RESET = '{granted: '0, waiting: '0, cf_count: '0,
                                   head: NULL_LINK, tail: NULL_LINK};

    function automatic logic link_ok(input logic [LINK_W-1:0] l);
        return l < LINK_W'(MAX_REQ);
    endfunction

    function automatic logic [NUM_MODES-1:0] mode_set(
        input logic [NUM_MODES-1:0][CNT_W-1:0] c);
        logic [NUM_MODES-1:0] m;
        for (int i = 0; i < NUM_MODES; i++) begin
            m[i] = c[i] != '0;
        end
        return m;
    endfunction

    function automatic logic clashes(input logic [MODE_W-1:0] mode,
                                     input logic [NUM_MODES-1:0] set);
        logic r;
        case (mode)
            3'd0: r = (CONFLICT[0] & set) != '0;
            3'd1: r = (CONFLICT[1] & set) != '0;
            3'd2: r = (CONFLICT[2] & set) != '0;
            3'd3: r = (CONFLICT[3] & set) != '0;
            3'd4: r = (CONFLICT[4] & set) != '0;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] dec_cnt(input logic [CNT_W-1:0] c);
        return (c != '0) ? c - CNT_W'(1) : c;
    endfunction

endpackage

[sv/iltm_datapath.sv]
// lock table datapath: request table, resource table, result buffer
module iltm_datapath import iltm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_in             i_item,
    input  logic [OP_W-1:0] i_op,
    output t_status         o_st,
    output t_out            o_result,
    output logic            o_result_valid
);

    localparam logic [1:0] WR_ROW  = 2'd0;
    localparam logic [1:0] WR_NEXT = 2'd1;
    localparam logic [1:0] WR_PREV = 2'd2;

    t_req              r_req [MAX_REQ];
    t_row              r_rtab [NUM_RES];
    t_bent             r_buf [MAX_REQ];

    t_in               r_in,    n_in;
    t_req              r_rq;
    t_row              r_row,   n_row;
    logic [RES_W-1:0]  r_res,   n_res;
    logic [LINK_W-1:0] r_it,    n_it;
    logic [LINK_W-1:0] r_p,     n_p;
    logic [LINK_W-1:0] r_n,     n_n;
    logic              r_check, n_check;
    logic              r_newly, n_newly;
    logic              r_err,   n_err;
    logic [ID_W:0]     r_cnt,   n_cnt;
    logic [ID_W:0]     r_rd,    n_rd;
    t_bent             r_bo;

    logic              rd_en;
    logic [ID_W-1:0]   rd_addr;
    logic              wr_en;
    logic [1:0]        wr_kind;
    logic [ID_W-1:0]   wr_addr;
    t_req              wr_row;
    logic [LINK_W-1:0] wr_link;
    logic              bw_en;
    t_bent             bw_data;

    logic [NUM_MODES-1:0] gset, wset;
    logic                 lk_err, lk_wait;
    logic [MODE_W-1:0]    lm, rm;

    assign gset    = mode_set(r_row.granted);
    assign wset    = mode_set(r_row.waiting);
    assign lm      = r_in.lock_mode;
    assign rm      = r_rq.mode;
    assign lk_err  = (lm > MODE_X) || (r_rq.status != ST_FREE);
    assign lk_wait = clashes(lm, gset) || ((r_row.cf_count == '0) && clashes(lm, wset));

    always_comb begin
        o_st.action    = r_in.action;
        o_st.lk_wait   = !lk_err && lk_wait;
        o_st.u_free    = r_rq.status == ST_FREE;
        o_st.u_granted = r_rq.status == ST_GRANTED;
        o_st.check     = r_check;
        o_st.it_null   = !link_ok(r_it);
        o_st.s_clash   = clashes(rm, gset);
        o_st.s_stop    = !link_ok(r_rq.prev) && !r_newly;
        o_st.s_x       = rm == MODE_X;
        o_st.last_out  = (r_rd + (ID_W+1)'(1)) == r_cnt;
    end

    always_comb begin
        n_in    = r_in;
        n_row   = r_row;
        n_res   = r_res;
        n_it    = r_it;
        n_p     = r_p;
        n_n     = r_n;
        n_check = r_check;
        n_newly = r_newly;
        n_err   = r_err;
        n_cnt   = r_cnt;
        n_rd    = r_rd;
        rd_en   = 1'b0;
        rd_addr = r_in.request_id;
        wr_en   = 1'b0;
        wr_kind = WR_ROW;
        wr_addr = r_in.request_id;
        wr_row  = REQ_RESET;
        wr_link = NULL_LINK;
        bw_en   = 1'b0;
        bw_data = '{id: r_in.request_id, outcome: OUT_ERROR};
        case (i_op)
            OP_LATCH: begin
                n_in    = i_item;
                rd_en   = 1'b1;
                rd_addr = i_item.request_id;
                n_row   = r_rtab[i_item.resource_slot];
                n_res   = i_item.resource_slot;
                n_cnt   = '0;
                n_err   = 1'b0;
            end
            OP_LOCK: begin
                bw_en = 1'b1;
                if (lk_err) begin
                    n_err = 1'b1;
                end else if (lk_wait) begin
                    wr_en  = 1'b1;
                    wr_row = '{resource: r_in.resource_slot, mode: lm, status: ST_WAITING,
                               compat: r_in.compat_first,
                               next: r_in.at_front ? r_row.head : NULL_LINK,
                               prev: r_in.at_front ? NULL_LINK : r_row.tail};
                    n_row.waiting[lm] = r_row.waiting[lm] + CNT_W'(1);
                    if (r_in.at_front) begin
                        n_p = r_row.head;
                        if (!link_ok(r_row.head)) n_row.tail = LINK_W'(r_in.request_id);
                        n_row.head = LINK_W'(r_in.request_id);
                    end else begin
                        n_p = r_row.tail;
                        if (!link_ok(r_row.tail)) n_row.head = LINK_W'(r_in.request_id);
                        n_row.tail = LINK_W'(r_in.request_id);
                    end
                    bw_data.outcome = OUT_WAITING;
                end else begin
                    wr_en  = 1'b1;
                    wr_row = '{resource: r_in.resource_slot, mode: lm, status: ST_GRANTED,
                               compat: r_in.compat_first, next: NULL_LINK, prev: NULL_LINK};
                    n_row.granted[lm] = r_row.granted[lm] + CNT_W'(1);
                    if (r_in.compat_first) n_row.cf_count = r_row.cf_count + CNT_W'(1);
                    bw_data.outcome = OUT_GRANTED;
                end
            end
            OP_LINK: begin
                if (link_ok(r_p)) begin
                    wr_en   = 1'b1;
                    wr_kind = r_in.at_front ? WR_PREV : WR_NEXT;
                    wr_addr = r_p[ID_W-1:0];
                    wr_link = LINK_W'(r_in.request_id);
                end
            end
            OP_UCHK: begin
                if (r_rq.status == ST_FREE) begin
                    bw_en = 1'b1;
                    n_err = 1'b1;
                end
            end
            OP_ULOAD: begin
                n_row = r_rtab[r_rq.resource];
                n_res = r_rq.resource;
            end
            OP_UREL: begin
                if (r_rq.status == ST_GRANTED) begin
                    n_row.granted[rm] = dec_cnt(r_row.granted[rm]);
                    if (r_rq.compat) n_row.cf_count = dec_cnt(r_row.cf_count);
                    n_check = r_row.granted[rm] <= CNT_W'(1);
                end else begin
                    n_row.waiting[rm] = dec_cnt(r_row.waiting[rm]);
                    n_p     = r_rq.prev;
                    n_n     = r_rq.next;
                    n_check = 1'b1;
                end
            end
            OP_UNLP: begin
                if (link_ok(r_p)) begin
                    wr_en   = 1'b1;
                    wr_kind = WR_NEXT;
                    wr_addr = r_p[ID_W-1:0];
                    wr_link = r_n;
                end else begin
                    n_row.head = r_n;
                end
            end
            OP_UNLN: begin
                if (link_ok(r_n)) begin
                    wr_en   = 1'b1;
                    wr_kind = WR_PREV;
                    wr_addr = r_n[ID_W-1:0];
                    wr_link = r_p;
                end else begin
                    n_row.tail = r_p;
                end
            end
            OP_UCLR: begin
                wr_en           = 1'b1;
                bw_en           = 1'b1;
                bw_data.outcome = OUT_RELEASED;
                n_it            = r_row.head;
                n_newly         = 1'b0;
            end
            OP_SRD: begin
                rd_en   = 1'b1;
                rd_addr = r_it[ID_W-1:0];
            end
            OP_SCHK: begin
                if (clashes(rm, gset)) begin
                    n_it = r_rq.next;
                end else begin
                    n_p = r_rq.prev;
                    n_n = r_rq.next;
                end
            end
            OP_SGRANT: begin
                wr_en       = 1'b1;
                wr_addr     = r_it[ID_W-1:0];
                wr_row      = r_rq;
                wr_row.status = ST_GRANTED;
                wr_row.next = NULL_LINK;
                wr_row.prev = NULL_LINK;
                n_row.waiting[rm] = dec_cnt(r_row.waiting[rm]);
                n_row.granted[rm] = r_row.granted[rm] + CNT_W'(1);
                if (r_rq.compat) begin
                    if (r_row.cf_count == '0) n_newly = 1'b1;
                    n_row.cf_count = r_row.cf_count + CNT_W'(1);
                end
                bw_en   = 1'b1;
                bw_data = '{id: r_it[ID_W-1:0], outcome: OUT_GRANTED};
                n_it    = r_n;
            end
            OP_WB: begin
                n_rd = '0;
            end
            OP_EOUT: begin
                n_rd = r_rd + (ID_W+1)'(1);
            end
            default: begin
            end
        endcase
        if (bw_en) n_cnt = r_cnt + (ID_W+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_REQ; i++) r_req[i] <= REQ_RESET;
            for (int i = 0; i < NUM_RES; i++) r_rtab[i] <= ROW_RESET;
            r_cnt   <= '0;
            r_rd    <= '0;
            r_err   <= 1'b0;
            r_check <= 1'b0;
            r_newly <= 1'b0;
            r_it    <= NULL_LINK;
        end else begin
            if (wr_en) begin
                case (wr_kind)
                    WR_NEXT: r_req[wr_addr].next <= wr_link;
                    WR_PREV: r_req[wr_addr].prev <= wr_link;
                    default: r_req[wr_addr] <= wr_row;
                endcase
            end
            if (i_op == OP_WB) r_rtab[r_res] <= r_row;
            r_cnt   <= n_cnt;
            r_rd    <= n_rd;
            r_err   <= n_err;
            r_check <= n_check;
            r_newly <= n_newly;
            r_it    <= n_it;
        end
    end

    // payload registers and result buffer
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_row <= n_row;
        r_res <= n_res;
        r_p   <= n_p;
        r_n   <= n_n;
        if (rd_en) r_rq <= r_req[rd_addr];
        if (bw_en) r_buf[r_cnt[ID_W-1:0]] <= bw_data;
        if (i_op == OP_ERD) r_bo <= r_buf[r_rd[ID_W-1:0]];
    end

    assign o_result_valid = i_op == OP_EOUT;
    always_comb begin
        o_result.out_request     = r_bo.id;
        o_result.outcome         = r_bo.outcome;
        o_result.waiters_pending = !r_err && link_ok(r_row.head);
        o_result.last            = o_st.last_out;
    end

`include "assert_macros.svh"

    `ILTM_ASSERT_IMPL(a_buf_bound, 1'b1, r_cnt <= (ID_W+1)'(MAX_REQ))

endmodule

[sv/iltm_ctrl.sv]
// lock table controller state machine
module iltm_ctrl import iltm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  t_status         i_st,
    output logic [OP_W-1:0] o_op,
    output logic            o_busy
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_LINK   = 4'd2;
    localparam logic [3:0] S_ULOAD  = 4'd3;
    localparam logic [3:0] S_UREL   = 4'd4;
    localparam logic [3:0] S_UUNP   = 4'd5;
    localparam logic [3:0] S_UUNN   = 4'd6;
    localparam logic [3:0] S_UCLR   = 4'd7;
    localparam logic [3:0] S_SRD    = 4'd8;
    localparam logic [3:0] S_SCHK   = 4'd9;
    localparam logic [3:0] S_GUNP   = 4'd10;
    localparam logic [3:0] S_GUNN   = 4'd11;
    localparam logic [3:0] S_GGRANT = 4'd12;
    localparam logic [3:0] S_WB     = 4'd13;
    localparam logic [3:0] S_ERD    = 4'd14;
    localparam logic [3:0] S_EOUT   = 4'd15;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op    = OP_LATCH;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (!i_st.action) begin
                    o_op    = OP_LOCK;
                    n_state = i_st.lk_wait ? S_LINK : S_WB;
                end else begin
                    o_op    = OP_UCHK;
                    n_state = i_st.u_free ? S_WB : S_ULOAD;
                end
            end
            S_LINK: begin
                o_op    = OP_LINK;
                n_state = S_WB;
            end
            S_ULOAD: begin
                o_op    = OP_ULOAD;
                n_state = S_UREL;
            end
            S_UREL: begin
                o_op    = OP_UREL;
                n_state = i_st.u_granted ? S_UCLR : S_UUNP;
            end
            S_UUNP: begin
                o_op    = OP_UNLP;
                n_state = S_UUNN;
            end
            S_UUNN: begin
                o_op    = OP_UNLN;
                n_state = S_UCLR;
            end
            S_UCLR: begin
                o_op    = OP_UCLR;
                n_state = i_st.check ? S_SRD : S_WB;
            end
            S_SRD: begin
                o_op    = OP_SRD;
                n_state = i_st.it_null ? S_WB : S_SCHK;
            end
            S_SCHK: begin
                o_op = OP_SCHK;
                if (i_st.s_clash) n_state = i_st.s_stop ? S_WB : S_SRD;
                else              n_state = S_GUNP;
            end
            S_GUNP: begin
                o_op    = OP_UNLP;
                n_state = S_GUNN;
            end
            S_GUNN: begin
                o_op    = OP_UNLN;
                n_state = S_GGRANT;
            end
            S_GGRANT: begin
                o_op    = OP_SGRANT;
                n_state = i_st.s_x ? S_WB : S_SRD;
            end
            S_WB: begin
                o_op    = OP_WB;
                n_state = S_ERD;
            end
            S_ERD: begin
                o_op    = OP_ERD;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                o_op    = OP_EOUT;
                n_state = i_st.last_out ? S_IDLE : S_ERD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;

`include "assert_macros.svh"

    `ILTM_ASSERT_NEXT(a_start_dec, r_state == S_IDLE && i_start, r_state == S_DEC)
    `ILTM_ASSERT_NEXT(a_last_idle, r_state == S_EOUT && i_st.last_out, r_state == S_IDLE)
    `ILTM_ASSERT_NEXT(a_wb_emit, r_state == S_WB, r_state == S_ERD && o_busy)

endmodule

[sv/intent_lock_table_manager_unit.sv]
// top level of the intent lock table manager
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------
//  input    | start high, busy low   | i_item (t_in)
//  result   | o_result_valid strobe  | o_result (t_out)
//
// a lock runs accept, evaluate, link (when it queues), write-back, then reads out each result
// an unlock runs accept, check, load, release, unlink (when it cancels a waiter), clear;
// a free slot skips to write-back; the scan passes over clashing waiters, grants others
// reset is synchronous; the request and resource tables come up empty at once
// results are strobed for one cycle each and the receiver cannot stall them;
// busy stays high until the last one
module intent_lock_table_manager_unit import iltm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output t_out o_result,
    output logic o_result_valid
);

    logic [OP_W-1:0] op;
    t_status         st;

    iltm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_st    (st),
        .o_op    (op),
        .o_busy  (busy)
    );

    iltm_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_op           (op),
        .o_st           (st),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule
